FILE: rtl/core/dual_motor_drive_safety_controller_unit_assert.svh
// ----------------------------------------------------------------------------
// Dual motor drive safety controller assertion macros
// Concurrent assertion forms for the controller module.
// ----------------------------------------------------------------------------
`ifndef DUAL_MOTOR_DRIVE_SAFETY_CONTROLLER_UNIT_ASSERT_SVH
`define DUAL_MOTOR_DRIVE_SAFETY_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DMD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define DMD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

FILE: rtl/core/dmd_pkg.sv
// ----------------------------------------------------------------------------
// Dual motor drive safety controller package
// Request and response types, field codes and fixed constants.
// ----------------------------------------------------------------------------
package dmd_pkg;

   typedef enum logic [1:0] {
      FUNC_MOTOR     = 2'd0,
      FUNC_TICK      = 2'd1,
      FUNC_ECHO      = 2'd2,
      FUNC_KEEPALIVE = 2'd3
   } dmd_func_type;

   typedef enum logic [1:0] {
      CAUSE_NONE      = 2'd0,
      CAUSE_HEARTBEAT = 2'd1,
      CAUSE_OBSTACLE  = 2'd2
   } dmd_cause_type;

   typedef enum logic [2:0] {
      CSR_GLOBAL_LIMIT = 3'd0,
      CSR_RIGHT_MIN    = 3'd1,
      CSR_LEFT_MIN     = 3'd2,
      CSR_RIGHT_MAX    = 3'd3,
      CSR_LEFT_MAX     = 3'd4,
      CSR_INVERT       = 3'd5,
      CSR_STOP_RANGE   = 3'd6,
      CSR_TIMEOUT      = 3'd7
   } dmd_csr_type;

   localparam logic [7:0] MOTOR_RIGHT = 8'd1;
   localparam logic [7:0] MOTOR_LEFT  = 8'd2;

   localparam logic [1:0] DIR_FORWARD  = 2'd1;
   localparam logic [1:0] DIR_BACKWARD = 2'd2;

   // floor(us * 0.01715) is exact as (us * DIST_RECIP) >> DIST_SHIFT for 15-bit us.
   localparam logic [24:0] DIST_RECIP = 25'd18414673;
   localparam int          DIST_SHIFT = 30;
   localparam logic [9:0]  DIST_MAX   = 10'd400;

   typedef struct packed {
      logic [1:0]         func;
      logic [7:0]         motor_id;
      logic [1:0]         direction;
      logic signed [15:0] speed;
      logic [14:0]        echo_us;
   } dmd_req_type;

   typedef struct packed {
      logic [7:0] right_duty;
      logic       right_reverse;
      logic [7:0] left_duty;
      logic       left_reverse;
      logic       right_running;
      logic       left_running;
      logic [8:0] distance_cm;
      logic [1:0] stop_cause;
   } dmd_rsp_type;

   typedef struct packed {
      logic       active;
      logic       reverse;
      logic [7:0] duty;
   } dmd_motor_type;

endpackage

FILE: rtl/core/dmd_motor_calc.sv
// ----------------------------------------------------------------------------
// Motor command evaluation
// Clamps a requested speed, applies the minimum duty and sets the direction pin.
// ----------------------------------------------------------------------------
module dmd_motor_calc
   import dmd_pkg::*;
(
   input  logic signed [15:0] speed,
   input  logic [1:0]         direction,
   input  logic [7:0]         global_limit,
   input  logic [7:0]         min_duty,
   input  logic [7:0]         max_duty,
   input  logic               invert,
   output dmd_motor_type      motor
);

   logic [14:0] spd_pos;
   logic [7:0]  spd_global;
   logic [7:0]  spd_clamped;
   logic        moving;

   always_comb begin
      spd_pos     = speed[15] ? 15'd0 : speed[14:0];
      spd_global  = (spd_pos > {7'd0, global_limit}) ? global_limit : spd_pos[7:0];
      spd_clamped = (spd_global > max_duty) ? max_duty : spd_global;
      moving      = (direction == DIR_FORWARD) || (direction == DIR_BACKWARD);
      motor.active = moving;
      if (moving) begin
         motor.duty    = ((spd_clamped != 8'd0) && (spd_clamped < min_duty)) ?
                         min_duty : spd_clamped;
         motor.reverse = (direction == DIR_BACKWARD) ^ invert;
      end else begin
         motor.duty    = 8'd0;
         motor.reverse = 1'b0;
      end
   end

endmodule

FILE: rtl/core/dmd_range.sv
// ----------------------------------------------------------------------------
// Echo range conversion
// Converts an echo pulse width in microseconds to a distance in centimeters.
// ----------------------------------------------------------------------------
module dmd_range
   import dmd_pkg::*;
(
   input  logic [14:0] echo_us,
   output logic [8:0]  distance_cm
);

   logic [39:0] product;
   logic [9:0]  quotient;

   assign product     = {25'd0, echo_us} * {15'd0, DIST_RECIP};
   assign quotient    = product[DIST_SHIFT +: 10];
   assign distance_cm = (quotient > DIST_MAX) ? 9'd0 : quotient[8:0];

endmodule

FILE: rtl/core/dual_motor_drive_safety_controller_unit.sv
// A request is held in the stage-one register, then written to the response register when the output is free.
// One request per cycle while rsp_stall does not hold the output; the motor, tick and echo work is one registered pass.
// The range conversion is a single constant multiply between the two registers.
// Reset is synchronous and active high; it restores the register defaults,
// stops both motors and clears the command age and the last distance.
// ----------------------------------------------------------------------------
// Dual motor drive safety controller
// Drives two motors from command requests with heartbeat and obstacle stops.
// ----------------------------------------------------------------------------
module dual_motor_drive_safety_controller_unit
   import dmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dmd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dmd_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

`include "dual_motor_drive_safety_controller_unit_assert.svh"

   logic [7:0]  global_limit_ff, right_min_ff, left_min_ff, right_max_ff, left_max_ff;
   logic [1:0]  invert_ff;
   logic [8:0]  stop_range_ff;
   logic [15:0] timeout_ff;

   logic          s1_valid_ff;
   dmd_req_type   s1_data_ff;
   logic          rsp_valid_ff;
   dmd_rsp_type   rsp_data_ff;
   dmd_rsp_type   rsp_data_in;

   dmd_motor_type right_ff, left_ff, right_in, left_in, cmd_motor;
   logic [15:0]   ms_ff, ms_in, ms_inc;
   logic [8:0]    dist_ff, dist_in, echo_dist;
   dmd_cause_type cause;

   logic out_free, process, sel_right, any_active;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign process   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   assign sel_right = (s1_data_ff.motor_id == MOTOR_RIGHT);

   dmd_motor_calc u_motor (
      .speed        (s1_data_ff.speed),
      .direction    (s1_data_ff.direction),
      .global_limit (global_limit_ff),
      .min_duty     (sel_right ? right_min_ff : left_min_ff),
      .max_duty     (sel_right ? right_max_ff : left_max_ff),
      .invert       (sel_right ? invert_ff[0] : invert_ff[1]),
      .motor        (cmd_motor)
   );

   dmd_range u_range (
      .echo_us     (s1_data_ff.echo_us),
      .distance_cm (echo_dist)
   );

   always_comb begin
      right_in   = right_ff;
      left_in    = left_ff;
      ms_in      = ms_ff;
      dist_in    = dist_ff;
      cause      = CAUSE_NONE;
      any_active = right_ff.active || left_ff.active;
      ms_inc     = (ms_ff == 16'hFFFF) ? ms_ff : ms_ff + 16'd1;
      case (dmd_func_type'(s1_data_ff.func))
         FUNC_MOTOR: begin
            if (sel_right) begin
               right_in = cmd_motor;
            end
            if (s1_data_ff.motor_id == MOTOR_LEFT) begin
               left_in = cmd_motor;
            end
            ms_in = 16'd0;
         end
         FUNC_TICK: begin
            ms_in = ms_inc;
            if (any_active && (ms_inc > timeout_ff)) begin
               right_in = '0;
               left_in  = '0;
               cause    = CAUSE_HEARTBEAT;
            end
         end
         FUNC_ECHO: begin
            dist_in = echo_dist;
            if ((echo_dist != 9'd0) && (echo_dist < stop_range_ff) && any_active) begin
               right_in = '0;
               left_in  = '0;
               cause    = CAUSE_OBSTACLE;
            end
         end
         FUNC_KEEPALIVE: begin
            ms_in = 16'd0;
         end
         default: begin
            ms_in = ms_ff;
         end
      endcase
      rsp_data_in.right_duty    = right_in.duty;
      rsp_data_in.right_reverse = right_in.reverse;
      rsp_data_in.left_duty     = left_in.duty;
      rsp_data_in.left_reverse  = left_in.reverse;
      rsp_data_in.right_running = right_in.active;
      rsp_data_in.left_running  = left_in.active;
      rsp_data_in.distance_cm   = dist_in;
      rsp_data_in.stop_cause    = cause;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         global_limit_ff <= 8'd180;
         right_min_ff    <= 8'd100;
         left_min_ff     <= 8'd100;
         right_max_ff    <= 8'd180;
         left_max_ff     <= 8'd180;
         invert_ff       <= 2'd0;
         stop_range_ff   <= 9'd10;
         timeout_ff      <= 16'd200;
      end else if (csr_valid && csr_ready) begin
         case (dmd_csr_type'(csr_index))
            CSR_GLOBAL_LIMIT: global_limit_ff <= csr_data[7:0];
            CSR_RIGHT_MIN:    right_min_ff    <= csr_data[7:0];
            CSR_LEFT_MIN:     left_min_ff     <= csr_data[7:0];
            CSR_RIGHT_MAX:    right_max_ff    <= csr_data[7:0];
            CSR_LEFT_MAX:     left_max_ff     <= csr_data[7:0];
            CSR_INVERT:       invert_ff       <= csr_data[1:0];
            CSR_STOP_RANGE:   stop_range_ff   <= csr_data[8:0];
            CSR_TIMEOUT:      timeout_ff      <= csr_data;
            default:          timeout_ff      <= timeout_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         right_ff     <= '0;
         left_ff      <= '0;
         ms_ff        <= 16'd0;
         dist_ff      <= 9'd0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (process) begin
            right_ff <= right_in;
            left_ff  <= left_in;
            ms_ff    <= ms_in;
            dist_ff  <= dist_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_data;
      end
      if (process) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `DMD_ASSERT_IMP(a_duty_running, clock, reset,
      rsp_valid_ff && (rsp_data_ff.right_duty != 8'd0), rsp_data_ff.right_running)
   `DMD_ASSERT_IMP(a_stop_idle, clock, reset,
      rsp_valid_ff && (rsp_data_ff.stop_cause != CAUSE_NONE),
      !rsp_data_ff.right_running && !rsp_data_ff.left_running &&
      (rsp_data_ff.right_duty == 8'd0) && (rsp_data_ff.left_duty == 8'd0))
   `DMD_ASSERT_IMP(a_obstacle_dist, clock, reset,
      rsp_valid_ff && (rsp_data_ff.stop_cause == CAUSE_OBSTACLE),
      rsp_data_ff.distance_cm != 9'd0)
   `DMD_ASSERT_IMP(a_idle_pin_low, clock, reset,
      !left_ff.active, !left_ff.reverse && (left_ff.duty == 8'd0))
   `DMD_ASSERT_NXT(a_drain, clock, reset,
      rsp_valid_ff && !rsp_stall && !s1_valid_ff, !rsp_valid_ff)

endmodule

FILE: verif/dual_motor_drive_safety_controller_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual motor drive safety controller testbench
// Drives command, tick, echo and keepalive requests through the controller
// under several register settings with random gaps between requests and random
// response back-pressure, predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module dual_motor_drive_safety_controller_unit_tb
   import dmd_pkg::*;
();

   localparam int ECHO_SCALE_NUM = 1715;
   localparam int ECHO_SCALE_DEN = 100000;
   localparam int ECHO_RANGE_CM  = 400;

   class motor_drive_scoreboard_type;
      logic [7:0]    speed_limit;
      logic [7:0]    right_min;
      logic [7:0]    left_min;
      logic [7:0]    right_max;
      logic [7:0]    left_max;
      logic [1:0]    invert;
      logic [8:0]    stop_range;
      logic [15:0]   timeout;
      dmd_motor_type right_m;
      dmd_motor_type left_m;
      logic [15:0]   age;
      logic [8:0]    last_dist;
      dmd_rsp_type   expected_q[$];
      int            requests;
      int            responses;
      int            heartbeat_stops;
      int            obstacle_stops;
      int            errors;

      function new();
         speed_limit = 8'd180;
         right_min = 8'd100;
         left_min = 8'd100;
         right_max = 8'd180;
         left_max = 8'd180;
         invert = 2'd0;
         stop_range = 9'd10;
         timeout = 16'd200;
         age = '0;
         last_dist = '0;
         halt_motors();
      endfunction

      function void halt_motors();
         right_m = '0;
         left_m = '0;
      endfunction

      function void write_reg(dmd_csr_type idx, logic [15:0] v);
         case (idx)
            CSR_GLOBAL_LIMIT: speed_limit = v[7:0];
            CSR_RIGHT_MIN:    right_min = v[7:0];
            CSR_LEFT_MIN:     left_min = v[7:0];
            CSR_RIGHT_MAX:    right_max = v[7:0];
            CSR_LEFT_MAX:     left_max = v[7:0];
            CSR_INVERT:       invert = v[1:0];
            CSR_STOP_RANGE:   stop_range = v[8:0];
            CSR_TIMEOUT:      timeout = v;
            default: ;
         endcase
      endfunction

      function dmd_motor_type drive_for(logic [1:0] dir, logic signed [15:0] spd,
                                        logic [7:0] floor_duty, logic [7:0] ceil_duty,
                                        logic inv);
         dmd_motor_type m;
         logic [15:0]   v;
         v = spd[15] ? 16'd0 : 16'(spd);
         if (v > 16'(speed_limit)) v = 16'(speed_limit);
         if (v > 16'(ceil_duty)) v = 16'(ceil_duty);
         m = '0;
         if (dir == DIR_FORWARD || dir == DIR_BACKWARD) begin
            if (v != 16'd0 && v < 16'(floor_duty)) v = 16'(floor_duty);
            m.duty = v[7:0];
            m.reverse = (dir == DIR_BACKWARD) ^ inv;
            m.active = 1'b1;
         end
         return m;
      endfunction

      function void note_request(dmd_req_type r);
         dmd_rsp_type   e;
         dmd_cause_type cause;
         int            range_cm;
         cause = CAUSE_NONE;
         requests++;
         case (r.func)
            FUNC_MOTOR: begin
               if (r.motor_id == MOTOR_RIGHT)
                  right_m = drive_for(r.direction, r.speed, right_min, right_max, invert[0]);
               else if (r.motor_id == MOTOR_LEFT)
                  left_m = drive_for(r.direction, r.speed, left_min, left_max, invert[1]);
               age = '0;
            end
            FUNC_TICK: begin
               if (age != 16'hFFFF) age = age + 16'd1;
               if ((right_m.active || left_m.active) && age > timeout) begin
                  halt_motors();
                  cause = CAUSE_HEARTBEAT;
                  heartbeat_stops++;
               end
            end
            FUNC_ECHO: begin
               range_cm = (int'(r.echo_us) * ECHO_SCALE_NUM) / ECHO_SCALE_DEN;
               last_dist = (range_cm > ECHO_RANGE_CM) ? 9'd0 : range_cm[8:0];
               if (last_dist != 9'd0 && last_dist < stop_range &&
                   (right_m.active || left_m.active)) begin
                  halt_motors();
                  cause = CAUSE_OBSTACLE;
                  obstacle_stops++;
               end
            end
            default: age = '0;
         endcase
         e.right_duty = right_m.duty;
         e.right_reverse = right_m.reverse;
         e.left_duty = left_m.duty;
         e.left_reverse = left_m.reverse;
         e.right_running = right_m.active;
         e.left_running = left_m.active;
         e.distance_cm = last_dist;
         e.stop_cause = cause;
         expected_q.push_back(e);
      endfunction

      function void compare_field(string name, logic [8:0] want, logic [8:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(dmd_rsp_type a);
         dmd_rsp_type e;
         responses++;
         if (expected_q.size() == 0) begin
            $error("response arrived with no request outstanding");
            errors++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("right_duty", 9'(e.right_duty), 9'(a.right_duty));
         compare_field("right_reverse", 9'(e.right_reverse), 9'(a.right_reverse));
         compare_field("left_duty", 9'(e.left_duty), 9'(a.left_duty));
         compare_field("left_reverse", 9'(e.left_reverse), 9'(a.left_reverse));
         compare_field("right_running", 9'(e.right_running), 9'(a.right_running));
         compare_field("left_running", 9'(e.left_running), 9'(a.left_running));
         compare_field("distance_cm", e.distance_cm, a.distance_cm);
         compare_field("stop_cause", 9'(e.stop_cause), 9'(a.stop_cause));
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   localparam logic [1:0] DIR_STOP    = 2'd0;
   localparam logic [1:0] DIR_UNUSED  = 2'd3;
   localparam int         STALL_LIMIT = 5000;

   typedef enum {SET_DIRECTED, SET_RANDOM, SET_LOW, SET_HIGH, SET_KEEP} settings_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   dmd_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   dmd_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   motor_drive_scoreboard_type sb = new();
   logic [15:0] reg_val [8];
   int          req_idle_pct = 11;
   int          rsp_idle_pct = 66;
   int          settings_done = 0;
   int          quiet_cycles = 0;

   dual_motor_drive_safety_controller_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
   end

   function automatic dmd_req_type make_req(logic [1:0] func, logic [7:0] id,
                                             logic [1:0] dir, logic signed [15:0] spd,
                                             logic [14:0] us);
      dmd_req_type r;
      r.func = func;
      r.motor_id = id;
      r.direction = dir;
      r.speed = spd;
      r.echo_us = us;
      return r;
   endfunction

   function automatic dmd_req_type random_noise();
      dmd_req_type r;
      r.func = 2'($urandom_range(0, 3));
      r.motor_id = 8'($urandom);
      r.direction = 2'($urandom);
      r.speed = 16'($urandom);
      r.echo_us = 15'($urandom_range(0, 30000));
      return r;
   endfunction

   function automatic dmd_req_type random_command();
      dmd_req_type r;
      int          pick;
      r = random_noise();
      r.func = FUNC_MOTOR;
      pick = $urandom_range(99);
      r.motor_id = (pick < 45) ? MOTOR_RIGHT : (pick < 90) ? MOTOR_LEFT : 8'($urandom);
      pick = $urandom_range(99);
      r.direction = (pick < 40) ? DIR_FORWARD : (pick < 80) ? DIR_BACKWARD :
                    (pick < 93) ? DIR_STOP : DIR_UNUSED;
      case ($urandom_range(0, 3))
         0: r.speed = 16'($urandom_range(0, 20));
         1: r.speed = 16'($urandom_range(0, 300));
         2: r.speed = 16'($urandom);
         default: r.speed = $urandom_range(0, 1) ? 16'sh7FFF : -16'sd1;
      endcase
      return r;
   endfunction

   function automatic dmd_req_type random_tick_or_echo(logic [1:0] func);
      dmd_req_type r;
      r = random_noise();
      r.func = func;
      if ($urandom_range(99) < 60) r.echo_us = 15'($urandom_range(0, 1200));
      return r;
   endfunction

   task automatic send_request(input dmd_req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic apply_settings(input settings_kind_type kind);
      dmd_csr_type idx;
      drain_responses();
      repeat (4) @(posedge clock);
      case (kind)
         SET_DIRECTED: begin
            reg_val[CSR_GLOBAL_LIMIT] = 16'd255;
            reg_val[CSR_RIGHT_MIN] = 16'd200;
            reg_val[CSR_LEFT_MIN] = 16'd0;
            reg_val[CSR_RIGHT_MAX] = 16'd50;
            reg_val[CSR_LEFT_MAX] = 16'd255;
            reg_val[CSR_INVERT] = 16'd3;
            reg_val[CSR_STOP_RANGE] = 16'd400;
            reg_val[CSR_TIMEOUT] = 16'd3;
         end
         SET_RANDOM: begin
            reg_val[CSR_GLOBAL_LIMIT] = 16'($urandom_range(0, 255));
            reg_val[CSR_RIGHT_MIN] = 16'($urandom_range(0, 255));
            reg_val[CSR_LEFT_MIN] = 16'($urandom_range(0, 255));
            reg_val[CSR_RIGHT_MAX] = 16'($urandom_range(0, 255));
            reg_val[CSR_LEFT_MAX] = 16'($urandom_range(0, 255));
            reg_val[CSR_INVERT] = 16'($urandom_range(0, 3));
            reg_val[CSR_STOP_RANGE] = 16'($urandom_range(0, 400));
            reg_val[CSR_TIMEOUT] = 16'($urandom_range(0, 30));
         end
         SET_LOW: begin
            idx = CSR_GLOBAL_LIMIT;
            do begin
               reg_val[idx] = 16'd0;
               idx = idx.next();
            end while (idx != CSR_GLOBAL_LIMIT);
         end
         SET_HIGH: begin
            reg_val[CSR_GLOBAL_LIMIT] = 16'd255;
            reg_val[CSR_RIGHT_MIN] = 16'd255;
            reg_val[CSR_LEFT_MIN] = 16'd255;
            reg_val[CSR_RIGHT_MAX] = 16'd255;
            reg_val[CSR_LEFT_MAX] = 16'd255;
            reg_val[CSR_INVERT] = 16'd3;
            reg_val[CSR_STOP_RANGE] = 16'd400;
            reg_val[CSR_TIMEOUT] = 16'hFFFF;
         end
         default: ;
      endcase
      idx = CSR_GLOBAL_LIMIT;
      do begin
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= reg_val[idx];
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(idx, reg_val[idx]);
         idx = idx.next();
      end while (idx != CSR_GLOBAL_LIMIT);
      csr_valid <= 1'b0;
      settings_done++;
   endtask

   task automatic run_random(input int quota);
      int goal;
      int n;
      goal = sb.requests + quota;
      while (sb.requests < goal) begin
         if ($urandom_range(99) < 3) drain_responses();
         repeat ($urandom_range(1, 3)) send_request(random_command());
         n = (reg_val[CSR_TIMEOUT] < 16'd36) ? int'(reg_val[CSR_TIMEOUT]) + 4 : 40;
         repeat ($urandom_range(0, n)) send_request(random_tick_or_echo(FUNC_TICK));
         if ($urandom_range(99) < 40) send_request(random_tick_or_echo(FUNC_ECHO));
         if ($urandom_range(99) < 15) send_request(random_noise());
      end
   endtask

   initial begin
      reg_val[CSR_GLOBAL_LIMIT] = 16'd180;
      reg_val[CSR_RIGHT_MIN] = 16'd100;
      reg_val[CSR_LEFT_MIN] = 16'd100;
      reg_val[CSR_RIGHT_MAX] = 16'd180;
      reg_val[CSR_LEFT_MAX] = 16'd180;
      reg_val[CSR_INVERT] = 16'd0;
      reg_val[CSR_STOP_RANGE] = 16'd10;
      reg_val[CSR_TIMEOUT] = 16'd200;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: clamps, minimum raise, stops, unknown motors and range edges.
      send_request(make_req(FUNC_ECHO, 8'd0, DIR_STOP, 16'sd0, 15'd0));
      send_request(make_req(FUNC_ECHO, 8'd0, DIR_STOP, 16'sd0, 15'd292));
      send_request(make_req(FUNC_MOTOR, MOTOR_RIGHT, DIR_FORWARD, 16'sh7FFF, 15'd0));
      send_request(make_req(FUNC_MOTOR, MOTOR_LEFT, DIR_BACKWARD, 16'sh8000, 15'd0));
      send_request(make_req(FUNC_MOTOR, MOTOR_RIGHT, DIR_FORWARD, 16'sd1, 15'd0));
      send_request(make_req(FUNC_MOTOR, MOTOR_LEFT, DIR_UNUSED, 16'sd500, 15'd0));
      send_request(make_req(FUNC_MOTOR, 8'd0, DIR_FORWARD, 16'sd50, 15'd0));
      send_request(make_req(FUNC_MOTOR, 8'hFF, DIR_BACKWARD, 16'sd50, 15'd0));
      send_request(make_req(FUNC_TICK, 8'd0, DIR_STOP, 16'sd0, 15'd0));
      send_request(make_req(FUNC_KEEPALIVE, 8'd0, DIR_STOP, 16'sd0, 15'd0));
      send_request(make_req(FUNC_ECHO, 8'd0, DIR_STOP, 16'sd0, 15'd30000));
      send_request(make_req(FUNC_ECHO, 8'd0, DIR_STOP, 16'sd0, 15'd23324));
      send_request(make_req(FUNC_ECHO, 8'd0, DIR_STOP, 16'sd0, 15'd23382));
      send_request(make_req(FUNC_MOTOR, MOTOR_LEFT, DIR_BACKWARD, 16'sd150, 15'd0));
      send_request(make_req(FUNC_ECHO, 8'd0, DIR_STOP, 16'sd0, 15'd292));
      send_request(make_req(FUNC_MOTOR, MOTOR_RIGHT, DIR_BACKWARD, 16'sd200, 15'd0));
      send_request(make_req(FUNC_MOTOR, MOTOR_RIGHT, DIR_STOP, 16'sd0, 15'd0));
      send_request(make_req(FUNC_ECHO, 8'd0, DIR_STOP, 16'sd0, 15'd583));

      // Minimum above maximum, inverted pins, a short heartbeat and the widest stop range.
      apply_settings(SET_DIRECTED);
      send_request(make_req(FUNC_MOTOR, MOTOR_RIGHT, DIR_FORWARD, 16'sd10, 15'd0));
      send_request(make_req(FUNC_MOTOR, MOTOR_LEFT, DIR_BACKWARD, 16'sd255, 15'd0));
      repeat (4) send_request(make_req(FUNC_TICK, 8'd0, DIR_STOP, 16'sd0, 15'd0));
      send_request(make_req(FUNC_MOTOR, MOTOR_LEFT, DIR_FORWARD, 16'sd300, 15'd0));
      send_request(make_req(FUNC_ECHO, 8'd0, DIR_STOP, 16'sd0, 15'd23324));
      send_request(make_req(FUNC_ECHO, 8'd0, DIR_STOP, 16'sd0, 15'd23323));

      apply_settings(SET_RANDOM);
      run_random(250);
      apply_settings(SET_LOW);
      run_random(250);

      drain_responses();
      req_idle_pct = 66;
      rsp_idle_pct = 11;
      apply_settings(SET_RANDOM);
      run_random(250);
      apply_settings(SET_HIGH);
      run_random(250);

      drain_responses();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      apply_settings(SET_RANDOM);
      run_random(250);

      // Let the command age grow under the longest timeout, then shorten it below the age.
      reg_val[CSR_TIMEOUT] = 16'hFFFF;
      apply_settings(SET_KEEP);
      send_request(make_req(FUNC_MOTOR, MOTOR_RIGHT, DIR_FORWARD, 16'sd120, 15'd0));
      repeat (40) send_request(make_req(FUNC_TICK, 8'd0, DIR_STOP, 16'sd0, 15'd0));
      reg_val[CSR_TIMEOUT] = 16'd30;
      apply_settings(SET_KEEP);
      send_request(make_req(FUNC_TICK, 8'd0, DIR_STOP, 16'sd0, 15'd0));
      send_request(make_req(FUNC_KEEPALIVE, 8'd0, DIR_STOP, 16'sd0, 15'd0));

      drain_responses();
      repeat (6) @(posedge clock);
      $display("Covered %0d requests and %0d responses across %0d register settings.",
               sb.requests, sb.responses, settings_done);
      $display("Safety stops observed: %0d heartbeat, %0d obstacle.",
               sb.heartbeat_stops, sb.obstacle_stops);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
